// ===== hdl/spq_pkg.sv =====
// types, codes and constants shared by the sorted priority queue
package spq_pkg;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 11;
  localparam int ENTRY_W  = KEY_W + HANDLE_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic                command;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [KEY_W-1:0]    out_key;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_WRITE,
    S_POP_RD,
    S_POP_OUT
  } state_t;

endpackage

// ===== hdl/spq_store.sv =====
// entry memory: one write port, one registered read port
module spq_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// sorted priority queue: sequencer, compare unit and entry memory
//
// Entries sit in one memory sorted by descending key, the smallest key at the
// top of the filled range. An item is taken when start is high and busy is
// low; busy stays high until its work is done, and the result is shown for
// one cycle on out_item with out_valid, which the receiver cannot hold off.
// With N entries held, an insert scans all N entries through the single
// read port for a duplicate and for its place, then moves the N - P entries
// below its place P up by one, one per cycle, then writes. Duplicates and
// full drops finish after the scan. The one memory port pair is why entries
// are scanned and moved one at a time.
module sorted_priority_queue #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  spq_pkg::in_item_t    in_item,
  output logic                 busy,
  output logic                 out_valid,
  output spq_pkg::out_item_t   out_item
);

  import spq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic                chk_r, chk_nxt;
  logic                dup_r, dup_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [HANDLE_W-1:0] hdl_r, hdl_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [ENTRY_W-1:0]  mem_wd;
  logic [AW-1:0]       mem_ra;
  logic [ENTRY_W-1:0]  mem_rd;

  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_hdl;
  logic [CW-1:0]       idx_dec;
  logic [CW-1:0]       cnt_dec;
  logic [CW-1:0]       cnt_inc;

  spq_store #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_W),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  assign rd_key  = mem_rd[ENTRY_W-1 -: KEY_W];
  assign rd_hdl  = mem_rd[HANDLE_W-1:0];
  assign idx_dec = idx_r - 1'b1;
  assign cnt_dec = cnt_r - 1'b1;
  assign cnt_inc = cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    wa_r  <= wa_nxt;
    chk_r <= chk_nxt;
    dup_r <= dup_nxt;
    key_r <= key_nxt;
    hdl_r <= hdl_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    wa_nxt        = wa_r;
    chk_nxt       = 1'b0;
    dup_nxt       = dup_r;
    key_nxt       = key_r;
    hdl_nxt       = hdl_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = wa_r;
    mem_wd        = mem_rd;
    mem_ra        = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = in_item.key;
          hdl_nxt = in_item.handle;
          if (in_item.command == CMD_INSERT) begin
            idx_nxt   = '0;
            pos_nxt   = '0;
            dup_nxt   = 1'b0;
            state_nxt = S_SCAN;
          end else if (cnt_r == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{ST_EMPTY, '0, '0, OCC_W'(cnt_r)};
          end else begin
            state_nxt = S_POP_RD;
          end
        end
      end

      S_SCAN: begin
        // compare the entry read last cycle
        if (chk_r) begin
          if (rd_key > key_r) begin
            pos_nxt = pos_r + 1'b1;
          end
          if (rd_key == key_r && rd_hdl == hdl_r) begin
            dup_nxt = 1'b1;
          end
        end
        if (idx_r != cnt_r) begin
          mem_ra  = idx_r[AW-1:0];
          idx_nxt = idx_r + 1'b1;
          chk_nxt = 1'b1;
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (dup_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{ST_DUPLICATE, '0, '0, OCC_W'(cnt_r)};
          state_nxt     = S_IDLE;
        end else if (cnt_r == FULL_CNT) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{ST_FULL, '0, '0, OCC_W'(cnt_r)};
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = cnt_r;
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // entry read last cycle moves up by one place
        if (chk_r) begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = mem_rd;
        end
        if (idx_r != pos_r) begin
          mem_ra  = idx_dec[AW-1:0];
          wa_nxt  = idx_r[AW-1:0];
          idx_nxt = idx_dec;
          chk_nxt = 1'b1;
        end else begin
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        mem_we        = 1'b1;
        mem_wa        = pos_r[AW-1:0];
        mem_wd        = {key_r, hdl_r};
        cnt_nxt       = cnt_inc;
        out_valid_nxt = 1'b1;
        out_nxt       = '{ST_INSERTED, '0, '0, OCC_W'(cnt_inc)};
        state_nxt     = S_IDLE;
      end

      S_POP_RD: begin
        mem_ra    = cnt_dec[AW-1:0];
        cnt_nxt   = cnt_dec;
        state_nxt = S_POP_OUT;
      end

      S_POP_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{ST_POPPED, rd_hdl, rd_key, OCC_W'(cnt_r)};
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the sorted priority queue with a shadow store and reply checks
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH = 1024;

  class min_queue_shadow;
    logic [KEY_W-1:0]    keys    [DEPTH];
    logic [HANDLE_W-1:0] handles [DEPTH];
    int unsigned         held;
    out_item_t           replies_due [$];
    int unsigned         faults;

    function new();
      held = 0;
      faults = 0;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      faults++;
    endtask

    function void log_command(input in_item_t it);
      out_item_t r;
      int unsigned pos;
      bit dup;
      r = '0;
      dup = 1'b0;
      if (it.command == CMD_INSERT) begin
        for (int unsigned i = 0; i < held; i++) begin
          if (keys[i] == it.key && handles[i] == it.handle) dup = 1'b1;
        end
        if (dup) begin
          r.status = ST_DUPLICATE;
        end else if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held && keys[pos] > it.key) pos++;
          for (int unsigned i = held; i > pos; i--) begin
            keys[i] = keys[i-1];
            handles[i] = handles[i-1];
          end
          keys[pos] = it.key;
          handles[pos] = it.handle;
          held++;
          r.status = ST_INSERTED;
        end
      end else if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        held--;
        r.status = ST_POPPED;
        r.out_handle = handles[held];
        r.out_key = keys[held];
      end
      r.occupancy = held[OCC_W-1:0];
      replies_due.push_back(r);
    endfunction

    task check_reply(input out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply with nothing due, status %0d", got.status));
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.out_handle !== want.out_handle)
          report($sformatf("handle %h, want %h", got.out_handle, want.out_handle));
        if (got.out_key !== want.out_key)
          report($sformatf("key %h, want %h", got.out_key, want.out_key));
        if (got.occupancy !== want.occupancy)
          report($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  min_queue_shadow shadow = new();
  int unsigned idle_pct = 6;

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) shadow.check_reply(out_item);
  end

  function automatic in_item_t mk(input logic cmd, input logic [HANDLE_W-1:0] h,
                                  input logic [KEY_W-1:0] k);
    in_item_t it;
    it.command = cmd;
    it.handle = h;
    it.key = k;
    return it;
  endfunction

  task automatic issue(input in_item_t it);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.log_command(it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  function automatic in_item_t random_command();
    in_item_t it;
    int unsigned pop_pct;
    int unsigned r;
    int unsigned idx;
    it = mk(CMD_INSERT, HANDLE_W'($urandom), KEY_W'($urandom));
    if (shadow.held == 0) pop_pct = 12;
    else if (shadow.held > 48) pop_pct = 70;
    else pop_pct = 42;
    if ($urandom_range(99) < pop_pct) begin
      it.command = CMD_POP;
      return it;
    end
    r = $urandom_range(99);
    if (r < 20 && shadow.held != 0) begin
      idx = $urandom_range(shadow.held - 1);
      it.handle = shadow.handles[idx];
      it.key = shadow.keys[idx];
    end else if (r < 50) begin
      it.handle = HANDLE_W'($urandom_range(3));
      it.key = KEY_W'($urandom_range(7));
    end else if (r < 60) begin
      case ($urandom_range(3))
        0: it.key = '0;
        1: it.key = '1;
        2: it.key = KEY_W'(1);
        default: it.key = 32'hFFFF_FFFE;
      endcase
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    logic [KEY_W-1:0] level;
    int unsigned stride;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases: empty pop, extremes, ties, duplicates
    issue(mk(CMD_POP, 16'hFFFF, 32'hFFFF_FFFF));
    issue(mk(CMD_INSERT, 16'h0000, 32'h0000_0000));
    issue(mk(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
    issue(mk(CMD_INSERT, 16'h0000, 32'h0000_0000));
    issue(mk(CMD_INSERT, 16'h0001, 32'h0000_0000));
    issue(mk(CMD_INSERT, 16'h0000, 32'hFFFF_FFFF));
    issue(mk(CMD_INSERT, 16'h5555, 32'h8000_0000));
    issue(mk(CMD_INSERT, 16'hAAAA, 32'h7FFF_FFFF));
    issue(mk(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
    issue(mk(CMD_INSERT, 16'hAAAA, 32'h7FFF_FFFF));
    repeat (7) issue(mk(CMD_POP, 16'h0000, 32'h0000_0000));
    issue(mk(CMD_POP, 16'h5555, 32'hAAAA_AAAA));
    pause_sender();

    repeat (300) issue(random_command());
    pause_sender();
    idle_pct = 71;
    repeat (300) issue(random_command());
    pause_sender();
    idle_pct = 0;
    repeat (250) issue(random_command());
    pause_sender();

    // fill to capacity with non-increasing keys so each item lands at the top, or ahead of any equal keys
    while (shadow.held != 0) issue(mk(CMD_POP, HANDLE_W'($urandom), KEY_W'($urandom)));
    level = '1;
    while (shadow.held < DEPTH) begin
      it = mk(CMD_INSERT, HANDLE_W'($urandom), level);
      issue(it);
      if ($urandom_range(49) == 0) issue(it);
      stride = ($urandom_range(9) == 0) ? 0 : $urandom_range(32'h3F_FFFF);
      level = (level > stride) ? level - stride : '0;
    end
    issue(mk(CMD_INSERT, shadow.handles[0], shadow.keys[0]));
    issue(mk(CMD_INSERT, shadow.handles[DEPTH-1], shadow.keys[DEPTH-1]));
    issue(mk(CMD_INSERT, HANDLE_W'($urandom), KEY_W'($urandom)));
    issue(mk(CMD_INSERT, 16'hFFFF, 32'h0000_0000));
    while (shadow.held != 0) issue(mk(CMD_POP, HANDLE_W'($urandom), KEY_W'($urandom)));
    issue(mk(CMD_POP, 16'h0000, 32'h0000_0000));

    pause_sender();
    repeat (20) @(posedge clk);
    if (shadow.faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d replies still due", shadow.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
